@@ design/fbc_pkg.sv @@
// ---------------------------------------------------------------------------
// fbc_pkg: frustum box classifier shared definitions
// Types, codes and default sizes used by the plane ring, the dot unit and
// the top level.
// ---------------------------------------------------------------------------
package fbc_pkg;

   localparam int PLANE_COUNT_DEF    = 6;
   localparam int POSITION_WIDTH_DEF = 32;

   localparam int NORMAL_W   = 16;
   localparam int CONST_W    = 32;
   localparam int CORNER_W   = 32;
   localparam int INDEX_W    = 3;
   localparam int FRAC_BITS  = 15;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 280;
   localparam int RSP_DATA_W = 8;
   localparam int VERDICT_W  = 2;

   typedef enum logic {
      CMD_WRITE_PLANE = 1'b0,
      CMD_CLASSIFY    = 1'b1
   } fbc_cmd_type;

   typedef enum logic [VERDICT_W-1:0] {
      VERDICT_OUTSIDE   = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_INSIDE    = 2'd2
   } fbc_verdict_type;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } fbc_state_type;

   typedef struct packed {
      logic signed [NORMAL_W-1:0] nx;
      logic signed [NORMAL_W-1:0] ny;
      logic signed [NORMAL_W-1:0] nz;
      logic signed [CONST_W-1:0]  c;
   } fbc_plane_type;

   // per-plane test outcome from the dot unit
   typedef struct packed {
      logic vld;
      logic far_neg;
      logic near_neg;
   } fbc_test_type;

endpackage

@@ design/frustum_box_classifier_top.sv @@
// ---------------------------------------------------------------------------
// frustum_box_classifier_top: six plane frustum test of axis aligned boxes
// Plane write: accepted in the idle state, gives no result.
// Classify: the corners are captured, then the planes rotate through a ring
// of cells into one shared dot unit, one plane per cycle; a drain state and
// a done state follow and load the result. With planes missing the box goes
// straight to done; requests wait for the result load. A held result stalls.
// Synchronous reset clears control, origins and plane valid bits; plane
// contents stay undefined until written.
// ---------------------------------------------------------------------------
module frustum_box_classifier_top
   import fbc_pkg::*;
#(
   parameter int PLANE_COUNT    = PLANE_COUNT_DEF,
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // plane_index, normal_x, normal_y, normal_z, plane_offset,
   // min_x, min_y, min_z, max_x, max_y, max_z, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // verdict, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = (PLANE_COUNT > 1) ? $clog2(PLANE_COUNT) : 1;
   localparam int EXT_W = (POSITION_WIDTH > CORNER_W + 1) ? POSITION_WIDTH : CORNER_W + 1;
   localparam logic signed [EXT_W-1:0] POS_MAX =
      EXT_W'($signed({1'b0, {(POSITION_WIDTH-1){1'b1}}}));
   localparam logic signed [EXT_W-1:0] POS_MIN =
      EXT_W'($signed({1'b1, {(POSITION_WIDTH-1){1'b0}}}));

   function automatic logic [POSITION_WIDTH-1:0] rebase(
      input logic signed [CORNER_W-1:0] corner,
      input logic signed [CORNER_W-1:0] origin
   );
      logic signed [EXT_W-1:0] d;
      d = EXT_W'(corner) - EXT_W'(origin);
      if (d > POS_MAX) begin
         d = POS_MAX;
      end else if (d < POS_MIN) begin
         d = POS_MIN;
      end
      return d[POSITION_WIDTH-1:0];
   endfunction

   // request fields
   logic [INDEX_W-1:0]         req_plane_index;
   fbc_plane_type              req_plane;
   logic signed [CORNER_W-1:0] req_min [3];
   logic signed [CORNER_W-1:0] req_max [3];
   fbc_cmd_type                req_cmd;

   assign req_plane_index = req_tdata[2:0];
   assign req_plane.nx    = req_tdata[18:3];
   assign req_plane.ny    = req_tdata[34:19];
   assign req_plane.nz    = req_tdata[50:35];
   assign req_plane.c     = req_tdata[82:51];
   assign req_min[0]      = req_tdata[114:83];
   assign req_min[1]      = req_tdata[146:115];
   assign req_min[2]      = req_tdata[178:147];
   assign req_max[0]      = req_tdata[210:179];
   assign req_max[1]      = req_tdata[242:211];
   assign req_max[2]      = req_tdata[274:243];
   assign req_cmd         = fbc_cmd_type'(req_tuser);

   fbc_state_type                  state_ff, state_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [PLANE_COUNT-1:0]         planes_valid_ff;
   logic signed [CORNER_W-1:0]     origin_ff [3];
   logic [2:0][POSITION_WIDTH-1:0] box_lo_ff, box_hi_ff;
   logic                           outside_ff, isect_ff;
   logic                           rsp_tvalid_ff;
   fbc_verdict_type                rsp_verdict_ff;

   logic            req_xfer;
   logic            shift;
   logic            issue;
   logic            load_rsp;
   logic            all_valid;
   fbc_verdict_type verdict;
   fbc_test_type    test;
   fbc_plane_type   ring [PLANE_COUNT];

   assign req_xfer  = req_tvalid && req_tready;
   assign all_valid = &planes_valid_ff;

   always_comb begin
      if (outside_ff) begin
         verdict = VERDICT_OUTSIDE;
      end else if (isect_ff) begin
         verdict = VERDICT_INTERSECT;
      end else begin
         verdict = VERDICT_INSIDE;
      end
   end

   // next state and control
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      req_tready = 1'b0;
      shift      = 1'b0;
      issue      = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cnt_in     = '0;
            if (req_tvalid && req_cmd == CMD_CLASSIFY) begin
               state_in = all_valid ? ST_SCAN : ST_DONE;
            end
         end
         ST_SCAN: begin
            shift  = 1'b1;
            issue  = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(PLANE_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // configuration and plane valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff[0]    <= '0;
         origin_ff[1]    <= '0;
         origin_ff[2]    <= '0;
         planes_valid_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_ORIGIN_X: origin_ff[0] <= csr_wdata;
               CSR_ORIGIN_Y: origin_ff[1] <= csr_wdata;
               CSR_ORIGIN_Z: origin_ff[2] <= csr_wdata;
               default: ;
            endcase
         end
         for (int i = 0; i < PLANE_COUNT; i++) begin
            if (req_xfer && req_cmd == CMD_WRITE_PLANE && 32'(req_plane_index) == i) begin
               planes_valid_ff[i] <= 1'b1;
            end
         end
      end
   end

   // rebased box corners, captured on a classify transfer
   always_ff @(posedge clock) begin
      if (req_xfer && req_cmd == CMD_CLASSIFY) begin
         for (int a = 0; a < 3; a++) begin
            box_lo_ff[a] <= rebase(req_min[a], origin_ff[a]);
            box_hi_ff[a] <= rebase(req_max[a], origin_ff[a]);
         end
      end
   end

   // verdict accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         outside_ff <= 1'b0;
         isect_ff   <= 1'b0;
      end else if (req_xfer && req_cmd == CMD_CLASSIFY) begin
         outside_ff <= 1'b0;
         isect_ff   <= !all_valid;
      end else if (test.vld) begin
         outside_ff <= outside_ff | test.far_neg;
         isect_ff   <= isect_ff | test.near_neg;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_verdict_ff <= verdict;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_verdict_ff);

   // plane ring: cell 0 feeds the dot unit, each cell takes its upper neighbor
   for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
      fbc_cell u_cell (
         .clock      (clock),
         .load       (req_xfer && req_cmd == CMD_WRITE_PLANE &&
                      32'(req_plane_index) == g),
         .load_plane (req_plane),
         .shift      (shift),
         .next_plane (ring[(g + 1) % PLANE_COUNT]),
         .plane      (ring[g])
      );
   end

   fbc_dot #(
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_dot (
      .clock  (clock),
      .reset  (reset),
      .issue  (issue),
      .plane  (ring[0]),
      .box_lo (box_lo_ff),
      .box_hi (box_hi_ff),
      .test   (test)
   );

   // a new result only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside done state");

   // dot unit outcomes only arrive while a box is being scanned
   a_test_in_scan: assert property (@(posedge clock) disable iff (reset)
      test.vld |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("plane test outside scan");

   // missing planes answer intersecting without a scan
   a_incomplete: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_cmd == CMD_CLASSIFY && !all_valid)
         |=> (state_ff == ST_DONE && isect_ff && !outside_ff))
      else $error("incomplete plane set not reported as intersecting");

   // a scan starts at plane zero and ends with the ring back home
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && state_in == ST_SCAN) |=> cnt_ff == '0)
      else $error("scan counter not cleared");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> $past(cnt_ff) == CNT_W'(PLANE_COUNT - 1))
      else $error("scan left before all planes tested");

endmodule

@@ design/fbc_cell.sv @@
// ---------------------------------------------------------------------------
// fbc_cell: one plane slot of the rotating plane ring
// Holds one plane; loads it from a write command or takes its neighbor's
// plane when the ring rotates.
// ---------------------------------------------------------------------------
module fbc_cell
   import fbc_pkg::*;
(
   input  logic          clock,
   input  logic          load,
   input  fbc_plane_type load_plane,
   input  logic          shift,
   input  fbc_plane_type next_plane,
   output fbc_plane_type plane
);

   fbc_plane_type plane_ff;
   fbc_plane_type plane_in;

   always_comb begin
      plane_in = plane_ff;
      if (load) begin
         plane_in = load_plane;
      end else if (shift) begin
         plane_in = next_plane;
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= plane_in;
   end

   assign plane = plane_ff;

endmodule

@@ design/fbc_dot.sv @@
// ---------------------------------------------------------------------------
// fbc_dot: support vertex dot product unit
// Picks the positive and negative support vertices of the box for one plane,
// registers the six axis products, then adds the scaled constant and flags
// a distance below zero.
// ---------------------------------------------------------------------------
module fbc_dot
   import fbc_pkg::*;
#(
   parameter int POSITION_WIDTH = POSITION_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                issue,
   input  fbc_plane_type                       plane,
   input  logic [2:0][POSITION_WIDTH-1:0]      box_lo,
   input  logic [2:0][POSITION_WIDTH-1:0]      box_hi,
   output fbc_test_type                        test
);

   localparam int PROD_W  = NORMAL_W + POSITION_WIDTH;
   localparam int CSH_W   = CONST_W + FRAC_BITS;
   localparam int SUM_W   = ((PROD_W > CSH_W) ? PROD_W : CSH_W) + 2;

   logic signed [NORMAL_W-1:0]       n_axis [3];
   logic signed [POSITION_WIDTH-1:0] far_v  [3];
   logic signed [POSITION_WIDTH-1:0] near_v [3];
   logic signed [PROD_W-1:0]         far_prod_in  [3];
   logic signed [PROD_W-1:0]         near_prod_in [3];
   logic signed [PROD_W-1:0]         far_prod_ff  [3];
   logic signed [PROD_W-1:0]         near_prod_ff [3];
   logic signed [CONST_W-1:0]        c_ff;
   logic                             vld_ff;
   logic signed [SUM_W-1:0]          c_scaled;
   logic signed [SUM_W-1:0]          far_sum;
   logic signed [SUM_W-1:0]          near_sum;

   always_comb begin
      n_axis[0] = plane.nx;
      n_axis[1] = plane.ny;
      n_axis[2] = plane.nz;
      for (int a = 0; a < 3; a++) begin
         // nonnegative normal: max corner is the positive vertex
         far_v[a]  = n_axis[a][NORMAL_W-1] ? $signed(box_lo[a]) : $signed(box_hi[a]);
         near_v[a] = n_axis[a][NORMAL_W-1] ? $signed(box_hi[a]) : $signed(box_lo[a]);
         far_prod_in[a]  = PROD_W'(n_axis[a]) * PROD_W'(far_v[a]);
         near_prod_in[a] = PROD_W'(n_axis[a]) * PROD_W'(near_v[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         far_prod_ff[a]  <= far_prod_in[a];
         near_prod_ff[a] <= near_prod_in[a];
      end
      c_ff <= plane.c;
   end

   always_comb begin
      c_scaled = SUM_W'(c_ff) <<< FRAC_BITS;
      far_sum  = SUM_W'(far_prod_ff[0]) + SUM_W'(far_prod_ff[1])
               + SUM_W'(far_prod_ff[2]) + c_scaled;
      near_sum = SUM_W'(near_prod_ff[0]) + SUM_W'(near_prod_ff[1])
               + SUM_W'(near_prod_ff[2]) + c_scaled;
      test.vld      = vld_ff;
      test.far_neg  = far_sum[SUM_W-1];
      test.near_neg = near_sum[SUM_W-1];
   end

endmodule

@@ sim/frustum_box_classifier_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// frustum_box_classifier_top_tb: self-checking bench for the frustum classifier
// Loads frustum planes and classifies boxes through the request stream. Each
// verdict is predicted from a local copy of the planes and origins and checked
// in order. Directed checks cover incomplete plane sets, ignored plane writes,
// exact boundaries, inverted boxes and rebase saturation; random traffic runs
// under three idle and stall profiles.
// ---------------------------------------------------------------------------
module frustum_box_classifier_top_tb;
   import fbc_pkg::*;

   localparam int PLANE_COUNT  = PLANE_COUNT_DEF;
   localparam int SETTLE_CYC   = PLANE_COUNT + 3 + 4;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RELOAD_EVERY = 50;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -64'sd2147483648;

   typedef struct packed {
      fbc_cmd_type                  cmd;
      logic [2:0][CORNER_W-1:0]     hi;
      logic [2:0][CORNER_W-1:0]     lo;
      logic signed [CONST_W-1:0]    c;
      logic [2:0][NORMAL_W-1:0]     n;
      logic [INDEX_W-1:0]           idx;
   } box_req_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // local copy of the block state
   logic [2:0][NORMAL_W-1:0]  plane_n [PLANE_COUNT];
   logic signed [CONST_W-1:0] plane_c [PLANE_COUNT];
   logic [PLANE_COUNT-1:0]    plane_loaded;
   logic signed [CORNER_W-1:0] origin [3];

   fbc_verdict_type verdict_queue [$];
   int err_count;
   int cycle_count;
   int req_idle_pct;
   int rsp_stall_pct;
   int unsigned frustum_half;
   int plane_writes;
   int boxes_sent;
   int verdict_seen [3];

   frustum_box_classifier_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // verdict checker
   always @(posedge clock) begin
      fbc_verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            $error("verdict: unexpected transfer, actual %0d", rsp_tdata[VERDICT_W-1:0]);
            err_count++;
         end else begin
            want = verdict_queue.pop_front();
            verdict_seen[want]++;
            if (rsp_tdata[VERDICT_W-1:0] !== want) begin
               $error("verdict: expected %0d, actual %0d", want, rsp_tdata[VERDICT_W-1:0]);
               err_count++;
            end
         end
      end
   end

   function automatic logic signed [CORNER_W-1:0] clamp32(input longint v);
      if (v > POS_MAX) return POS_MAX[CORNER_W-1:0];
      if (v < POS_MIN) return POS_MIN[CORNER_W-1:0];
      return v[CORNER_W-1:0];
   endfunction

   function automatic longint srand_span(input int unsigned span);
      return longint'($urandom_range(0, 2 * span)) - longint'(span);
   endfunction

   function automatic longint rebase(input logic [CORNER_W-1:0] corner,
                                     input logic signed [CORNER_W-1:0] org);
      longint d;
      d = longint'($signed(corner)) - longint'(org);
      return longint'(clamp32(d));
   endfunction

   function automatic fbc_verdict_type classify_box(input box_req_type it);
      longint lo_r [3];
      longint hi_r [3];
      longint far_d;
      longint near_d;
      longint nv;
      fbc_verdict_type v;
      if (plane_loaded != '1) return VERDICT_INTERSECT;
      for (int a = 0; a < 3; a++) begin
         lo_r[a] = rebase(it.lo[a], origin[a]);
         hi_r[a] = rebase(it.hi[a], origin[a]);
      end
      v = VERDICT_INSIDE;
      for (int k = 0; k < PLANE_COUNT; k++) begin
         far_d = longint'(plane_c[k]) * 32768;
         near_d = far_d;
         for (int a = 0; a < 3; a++) begin
            nv = longint'($signed(plane_n[k][a]));
            if (nv >= 0) begin
               far_d += nv * hi_r[a];
               near_d += nv * lo_r[a];
            end else begin
               far_d += nv * lo_r[a];
               near_d += nv * hi_r[a];
            end
         end
         if (far_d < 0) return VERDICT_OUTSIDE;
         if (near_d < 0) v = VERDICT_INTERSECT;
      end
      return v;
   endfunction

   function automatic box_req_type junk_req();
      box_req_type it;
      it.cmd = fbc_cmd_type'($urandom_range(1));
      it.idx = INDEX_W'($urandom_range(7));
      for (int a = 0; a < 3; a++) begin
         it.n[a] = NORMAL_W'($urandom_range(65535));
         it.lo[a] = $urandom;
         it.hi[a] = $urandom;
      end
      it.c = $urandom;
      return it;
   endfunction

   function automatic box_req_type plane_req(input int idx, input longint nx, input longint ny,
                                             input longint nz, input longint c);
      box_req_type it;
      it = junk_req();
      it.cmd = CMD_WRITE_PLANE;
      it.idx = INDEX_W'(idx);
      it.n[0] = nx[NORMAL_W-1:0];
      it.n[1] = ny[NORMAL_W-1:0];
      it.n[2] = nz[NORMAL_W-1:0];
      it.c = c[CONST_W-1:0];
      return it;
   endfunction

   function automatic box_req_type box_req(input longint lx, input longint ly, input longint lz,
                                           input longint hx, input longint hy, input longint hz);
      box_req_type it;
      it = junk_req();
      it.cmd = CMD_CLASSIFY;
      it.lo[0] = clamp32(lx);
      it.lo[1] = clamp32(ly);
      it.lo[2] = clamp32(lz);
      it.hi[0] = clamp32(hx);
      it.hi[1] = clamp32(hy);
      it.hi[2] = clamp32(hz);
      return it;
   endfunction

   task automatic send_req(input box_req_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= it.cmd;
      req_tdata <= REQ_DATA_W'({it.hi, it.lo, it.c, it.n, it.idx});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (it.cmd == CMD_WRITE_PLANE) begin
         plane_writes++;
         if (it.idx < PLANE_COUNT) begin
            plane_n[it.idx] = it.n;
            plane_c[it.idx] = it.c;
            plane_loaded[it.idx] = 1'b1;
         end
      end else begin
         boxes_sent++;
         verdict_queue.push_back(classify_box(it));
      end
   endtask

   // lower valid, let all verdicts arrive and the pipe empty
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // writes x, y, z and one index past the last register
   task automatic set_origin(input longint ox, input longint oy, input longint oz);
      logic [CSR_DATA_W-1:0] vals [4];
      vals[0] = ox[CSR_DATA_W-1:0];
      vals[1] = oy[CSR_DATA_W-1:0];
      vals[2] = oz[CSR_DATA_W-1:0];
      vals[3] = $urandom;
      for (int i = 0; i < 4; i++) begin
         csr_wr_en <= 1'b1;
         case (i)
            0: csr_index <= CSR_ORIGIN_X;
            1: csr_index <= CSR_ORIGIN_Y;
            2: csr_index <= CSR_ORIGIN_Z;
            default: csr_index <= CSR_UNUSED;
         endcase
         csr_wdata <= vals[i];
         @(posedge clock);
         if (i < 3) origin[i] = vals[i];
      end
      csr_wr_en <= 1'b0;
   endtask

   // plane k bounds axis k/2 from below (even k) or above (odd k) near +-half
   function automatic box_req_type frustum_plane(input int k, input int unsigned half);
      longint nv [3];
      longint m;
      int unsigned tilt;
      tilt = ($urandom_range(3) == 0) ? 0 : $urandom_range(3000);
      for (int a = 0; a < 3; a++) nv[a] = srand_span(tilt);
      m = $urandom_range(16384, 32767);
      nv[k / 2] = (k % 2 == 0) ? m : -m;
      if (k % 2 == 1 && $urandom_range(7) == 0) nv[k / 2] = -32768;
      return plane_req(k, nv[0], nv[1], nv[2], (longint'(half) * m) >>> 15);
   endfunction

   task automatic load_frustum();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: frustum_half = $urandom_range(1, 2000);
         5, 6, 7:       frustum_half = $urandom_range(1, 1 << 20);
         default:       frustum_half = $urandom_range(1, 1 << 30);
      endcase
      for (int k = 0; k < PLANE_COUNT; k++) send_req(frustum_plane(k, frustum_half));
   endtask

   function automatic box_req_type frustum_box();
      longint lo_v [3];
      longint hi_v [3];
      longint ctr;
      longint half;
      int sel;
      sel = $urandom_range(19);
      for (int a = 0; a < 3; a++) begin
         ctr = srand_span(2 * frustum_half);
         half = (sel < 2) ? 0 : $urandom_range(0, frustum_half >> $urandom_range(0, 6));
         lo_v[a] = ctr - half + origin[a];
         hi_v[a] = ctr + half + origin[a];
         if (sel == 2 && a == 0) begin
            ctr = lo_v[a];
            lo_v[a] = hi_v[a] + 1;
            hi_v[a] = ctr;
         end
      end
      return box_req(lo_v[0], lo_v[1], lo_v[2], hi_v[0], hi_v[1], hi_v[2]);
   endfunction

   task automatic test_planes_incomplete();
      send_req(box_req(-10, -10, -10, 10, 10, 10));
      send_req(plane_req(0, 16384, 0, 0, 500));
      send_req(plane_req(1, -32768, 0, 0, 1000));
      send_req(plane_req(2, 0, 16384, 0, 500));
      send_req(plane_req(3, 0, -32768, 0, 1000));
      send_req(plane_req(4, 0, 0, 16384, 500));
      send_req(box_req(-10, -10, -10, 10, 10, 10));
      // indexes past the last plane are dropped
      send_req(plane_req(6, 0, 0, -32768, 1000));
      send_req(plane_req(7, 0, 0, -32768, 1000));
      send_req(box_req(0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_plane_boundaries();
      send_req(plane_req(5, 0, 0, -32768, 1000));
      send_req(box_req(-500, -500, -500, 500, 500, 500));
      send_req(box_req(500, -500, -500, 1500, 500, 500));
      send_req(box_req(1500, -500, -500, 2000, 500, 500));
      // point exactly on two planes counts as inside
      send_req(box_req(1000, -1000, 0, 1000, -1000, 0));
      send_req(box_req(1001, 0, 0, 1001, 0, 0));
      send_req(box_req(600, 0, 0, -600, 0, 0));
      send_req(box_req(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
   endtask

   task automatic test_rebase_saturation();
      wait_drained();
      set_origin(POS_MIN, POS_MAX, 0);
      send_req(box_req(POS_MAX, POS_MIN, 5, POS_MAX, POS_MIN, 5));
      send_req(box_req(POS_MIN, POS_MAX, POS_MIN, POS_MIN, POS_MAX, POS_MAX));
      wait_drained();
      set_origin(POS_MAX, POS_MIN, POS_MIN);
      send_req(box_req(POS_MIN, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
      send_req(box_req(POS_MAX - 900, POS_MIN + 900, POS_MIN, POS_MAX, POS_MIN + 900, POS_MIN));
      wait_drained();
      set_origin(0, 0, 0);
   endtask

   task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count,
                                      input bit pause_mid);
      int since_reload;
      int sel;
      box_req_type it;
      wait_drained();
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      case ($urandom_range(2))
         0: set_origin(srand_span(1000), srand_span(1000), srand_span(1000));
         1: set_origin(longint'($signed($urandom)), longint'($signed($urandom)),
                       longint'($signed($urandom)));
         default: set_origin(POS_MAX - $urandom_range(100), POS_MIN + $urandom_range(100),
                             srand_span(1 << 30));
      endcase
      load_frustum();
      since_reload = 0;
      for (int i = 0; i < count; i++) begin
         if (since_reload >= RELOAD_EVERY) begin
            load_frustum();
            since_reload = 0;
         end
         if (pause_mid && i == count / 2) wait_drained();
         sel = $urandom_range(99);
         if (sel < 6) it = frustum_plane($urandom_range(PLANE_COUNT - 1), frustum_half);
         else if (sel < 80) it = frustum_box();
         else it = junk_req();
         send_req(it);
         since_reload++;
      end
   endtask

   initial begin
      err_count = 0;
      cycle_count = 0;
      plane_writes = 0;
      boxes_sent = 0;
      verdict_seen = '{0, 0, 0};
      plane_loaded = '0;
      for (int a = 0; a < 3; a++) origin[a] = '0;
      req_idle_pct = 13;
      rsp_stall_pct = 60;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_origin(0, 0, 0);
      test_planes_incomplete();
      test_plane_boundaries();
      test_rebase_saturation();
      test_random_traffic(13, 60, 320, 1'b1);
      test_random_traffic(60, 13, 320, 1'b0);
      test_random_traffic(0, 0, 320, 1'b0);
      wait_drained();

      $display("sent %0d plane writes and %0d boxes", plane_writes, boxes_sent);
      $display("verdicts checked: %0d outside, %0d intersecting, %0d inside",
               verdict_seen[VERDICT_OUTSIDE], verdict_seen[VERDICT_INTERSECT],
               verdict_seen[VERDICT_INSIDE]);
      if (err_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/fbc_pkg.sv
design/fbc_cell.sv
design/fbc_dot.sv
design/frustum_box_classifier_top.sv
sim/frustum_box_classifier_top_tb.sv
